>>> sv/idb_pkg.sv
// Shared types and constants of the inverse depth back-projection core.
package idb_pkg;

    localparam int IN_W      = 24;
    localparam int DIM_W     = 11;
    localparam int COEF_W    = 24;
    localparam int GRAD_W    = 16;
    localparam int INT_W     = 8;
    localparam int IDX_W     = 20;
    localparam int COORD_W   = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FOCAL_X_INV  = 3'd2;
    localparam logic [2:0] REG_FOCAL_Y_INV  = 3'd3;
    localparam logic [2:0] REG_CENTER_X     = 3'd4;
    localparam logic [2:0] REG_CENTER_Y     = 3'd5;

    typedef struct packed {
        logic        [DIM_W-1:0]  image_width;
        logic        [DIM_W-1:0]  image_height;
        logic signed [COEF_W-1:0] focal_x_inverse;
        logic signed [COEF_W-1:0] focal_y_inverse;
        logic signed [COEF_W-1:0] center_x_term;
        logic signed [COEF_W-1:0] center_y_term;
    } t_cfg;

    // Fields carried alongside the rays from front to back.
    typedef struct packed {
        logic signed [IN_W-1:0]   inv_depth;
        logic signed [IN_W-1:0]   variance;
        logic        [INT_W-1:0]  intensity;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic        [IDX_W-1:0]  pixel_index;
        logic        [IDX_W-1:0]  point_number;
    } t_pass;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_RUN,
        BACK_DONE
    } t_back_state;

endpackage

>>> sv/inverse_depth_backprojection_core.sv
// A kept pixel passes the queue, then the divider (load, RAY_W+10 divider steps, result
// register) before it shows on the result ports; it waits longer while results are held.
// Throughput: one pixel a cycle while the queue has room; the divider takes one point at a
// time, loading the next after the last is registered. RAY_W = 26 + clog2 of the larger dimension.
// Reset (synchronous, active low) clears counters, queue and divider, and loads the
// register defaults; payload registers are not reset.
module inverse_depth_backprojection_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [idb_pkg::ADDR_W-1:0]          paddr,
    input  logic [idb_pkg::DATA_W-1:0]          pwdata,
    output logic [idb_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic signed [idb_pkg::IN_W-1:0]     i_inv_depth,
    input  logic signed [idb_pkg::IN_W-1:0]     i_depth_variance,
    input  logic        [idb_pkg::INT_W-1:0]    i_intensity,
    input  logic signed [idb_pkg::GRAD_W-1:0]   i_grad_x,
    input  logic signed [idb_pkg::GRAD_W-1:0]   i_grad_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [idb_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [idb_pkg::COORD_W-1:0]  o_point_y,
    output logic signed [idb_pkg::COORD_W-1:0]  o_point_z,
    output logic signed [idb_pkg::GRAD_W-1:0]   o_out_grad_x,
    output logic signed [idb_pkg::GRAD_W-1:0]   o_out_grad_y,
    output logic        [idb_pkg::INT_W-1:0]    o_out_intensity,
    output logic signed [idb_pkg::IN_W-1:0]     o_out_variance,
    output logic        [idb_pkg::IDX_W-1:0]    o_pixel_index,
    output logic        [idb_pkg::IDX_W-1:0]    o_point_number
);
    import idb_pkg::*;

    // Ray width follows the larger counter: focal (24) times counter plus offset.
    localparam int CW_MAX = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                            $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
    localparam int RAY_W  = COEF_W + CW_MAX + 2;
    localparam int QW     = 2 * RAY_W + $bits(t_pass);

    t_cfg  r_cfg;
    logic  cfg_wr;
    logic  f_wr, q_full, q_empty, q_rd;
    logic signed [RAY_W-1:0] f_ray_x, f_ray_y, b_ray_x, b_ray_y;
    t_pass f_pass, b_pass, o_pass;
    logic [QW-1:0] q_rdata;

    // Configuration: write on the access phase, read back sign-extended (dimensions zero-extended).
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= DIM_W'(640);
            r_cfg.image_height    <= DIM_W'(480);
            r_cfg.focal_x_inverse <= COEF_W'(8389);
            r_cfg.focal_y_inverse <= COEF_W'(8389);
            r_cfg.center_x_term   <= '0;
            r_cfg.center_y_term   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_IMAGE_WIDTH:  r_cfg.image_width     <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height    <= pwdata[DIM_W-1:0];
                REG_FOCAL_X_INV:  r_cfg.focal_x_inverse <= pwdata[COEF_W-1:0];
                REG_FOCAL_Y_INV:  r_cfg.focal_y_inverse <= pwdata[COEF_W-1:0];
                REG_CENTER_X:     r_cfg.center_x_term   <= pwdata[COEF_W-1:0];
                REG_CENTER_Y:     r_cfg.center_y_term   <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_cfg.image_height);
            REG_FOCAL_X_INV:  prdata = DATA_W'(r_cfg.focal_x_inverse);
            REG_FOCAL_Y_INV:  prdata = DATA_W'(r_cfg.focal_y_inverse);
            REG_CENTER_X:     prdata = DATA_W'(r_cfg.center_x_term);
            REG_CENTER_Y:     prdata = DATA_W'(r_cfg.center_y_term);
            default:          prdata = '0;
        endcase
    end

    // Hold off requests only when the queue cannot take a kept pixel.
    assign full = q_full;

    idb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RAY_W      (RAY_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_push           (push),
        .i_q_full         (q_full),
        .i_inv_depth      (i_inv_depth),
        .i_depth_variance (i_depth_variance),
        .i_intensity      (i_intensity),
        .i_grad_x         (i_grad_x),
        .i_grad_y         (i_grad_y),
        .o_wr             (f_wr),
        .o_ray_x          (f_ray_x),
        .o_ray_y          (f_ray_y),
        .o_pass           (f_pass)
    );

    idb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_wdata ({f_ray_x, f_ray_y, f_pass}),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_ray_x, b_ray_y, b_pass} = q_rdata;

    idb_back #(
        .RAY_W (RAY_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_ray_x   (b_ray_x),
        .i_ray_y   (b_ray_y),
        .i_pass    (b_pass),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z),
        .o_pass    (o_pass)
    );

    assign o_out_grad_x    = o_pass.grad_x;
    assign o_out_grad_y    = o_pass.grad_y;
    assign o_out_intensity = o_pass.intensity;
    assign o_out_variance  = o_pass.variance;
    assign o_pixel_index   = o_pass.pixel_index;
    assign o_point_number  = o_pass.point_number;

endmodule

>>> sv/idb_front.sv
// Front part: pixel counters, border and validity test, ray and index formation.
module idb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int RAY_W      = 36
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  idb_pkg::t_cfg                i_cfg,
    input  logic                         i_push,
    input  logic                         i_q_full,
    input  logic signed [idb_pkg::IN_W-1:0]   i_inv_depth,
    input  logic signed [idb_pkg::IN_W-1:0]   i_depth_variance,
    input  logic        [idb_pkg::INT_W-1:0]  i_intensity,
    input  logic signed [idb_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [idb_pkg::GRAD_W-1:0] i_grad_y,
    output logic                         o_wr,
    output logic signed [RAY_W-1:0]      o_ray_x,
    output logic signed [RAY_W-1:0]      o_ray_y,
    output idb_pkg::t_pass               o_pass
);
    import idb_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW_A = (WW > DIM_W) ? WW : DIM_W;
    localparam int CMPW_B = (HW > DIM_W) ? HW : DIM_W;
    localparam int PXW   = COEF_W + CW + 1;
    localparam int PYW   = COEF_W + RW + 1;
    localparam int PIXW  = RW + WW + 1;

    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [IDX_W-1:0]  r_points, n_points;
    logic [CMPW_A-1:0] w_ext;
    logic [CMPW_B-1:0] h_ext;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [WW-1:0]     col_p1;
    logic [HW-1:0]     row_p1;
    logic              accept, inner, keep;
    logic signed [PXW-1:0] prod_x;
    logic signed [PYW-1:0] prod_y;
    logic [PIXW-1:0]   pix_full;

    assign w_ext = CMPW_A'(i_cfg.image_width);
    assign h_ext = CMPW_B'(i_cfg.image_height);

    always_comb begin
        if (w_ext < CMPW_A'(3)) begin
            w_eff = WW'(3);
        end else if (w_ext > CMPW_A'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_ext);
        end
        if (h_ext < CMPW_B'(3)) begin
            h_eff = HW'(3);
        end else if (h_ext > CMPW_B'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(h_ext);
        end
    end

    assign col_p1 = WW'(r_col) + WW'(1);
    assign row_p1 = HW'(r_row) + HW'(1);
    assign accept = i_push && !i_q_full;
    assign inner  = (r_col != '0) && (col_p1 < w_eff) && (r_row != '0) && (row_p1 < h_eff);
    assign keep   = inner && (i_depth_variance > 0) && (i_inv_depth != 0);

    assign prod_x   = i_cfg.focal_x_inverse * $signed({1'b0, r_col});
    assign prod_y   = i_cfg.focal_y_inverse * $signed({1'b0, r_row});
    assign pix_full = PIXW'(r_col) + PIXW'(r_row) * PIXW'(w_eff);

    assign o_wr    = accept && keep;
    assign o_ray_x = RAY_W'(prod_x) + RAY_W'(i_cfg.center_x_term);
    assign o_ray_y = RAY_W'(prod_y) + RAY_W'(i_cfg.center_y_term);

    always_comb begin
        o_pass.inv_depth    = i_inv_depth;
        o_pass.variance     = i_depth_variance;
        o_pass.intensity    = i_intensity;
        o_pass.grad_x       = i_grad_x;
        o_pass.grad_y       = i_grad_y;
        o_pass.pixel_index  = IDX_W'(pix_full);
        o_pass.point_number = r_points;
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_points = r_points;
        if (accept) begin
            if (keep) begin
                n_points = r_points + IDX_W'(1);
            end
            if (row_p1 >= h_eff) begin
                n_row = '0;
                if (col_p1 >= w_eff) begin
                    n_col    = '0;
                    n_points = '0;
                end else begin
                    n_col = CW'(col_p1);
                end
            end else begin
                n_row = RW'(row_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_points <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_points <= n_points;
        end
    end

endmodule

>>> sv/idb_queue.sv
// Short register queue between front and back parts.
module idb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    import idb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(do_wr) - (PW+1)'(do_rd);
        end
    end

endmodule

>>> sv/idb_back.sv
// Back part: three-lane radix-2 divider, saturation and result register.
module idb_back #(
    parameter int RAY_W = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_rd,
    input  logic signed [RAY_W-1:0]       i_ray_x,
    input  logic signed [RAY_W-1:0]       i_ray_y,
    input  idb_pkg::t_pass                i_pass,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [idb_pkg::COORD_W-1:0] o_point_x,
    output logic signed [idb_pkg::COORD_W-1:0] o_point_y,
    output logic signed [idb_pkg::COORD_W-1:0] o_point_z,
    output idb_pkg::t_pass                o_pass
);
    import idb_pkg::*;

    localparam int NUMW = RAY_W + 10;
    localparam int DENW = IN_W;
    localparam int CNTW = $clog2(NUMW);
    localparam int LANES = 3;

    t_back_state r_state, n_state;
    logic [NUMW-1:0] r_num [LANES];
    logic [DENW-1:0] r_rem [LANES];
    logic [DENW-1:0] r_den;
    logic [LANES-1:0] r_neg;
    logic [CNTW-1:0] r_cnt;
    t_pass           r_pass;
    logic            r_ovalid;
    logic            last_step, load_out;
    logic [NUMW-1:0] num_x, num_y, mag_x, mag_y;
    logic [DENW-1:0] mag_d;
    logic [NUMW-1:0] step_num [LANES];
    logic [DENW-1:0] step_rem [LANES];
    logic [COORD_W-1:0] sat [LANES];

    assign num_x = {i_ray_x, 10'b0};
    assign num_y = {i_ray_y, 10'b0};
    assign mag_x = i_ray_x[RAY_W-1] ? (~num_x + NUMW'(1)) : num_x;
    assign mag_y = i_ray_y[RAY_W-1] ? (~num_y + NUMW'(1)) : num_y;
    assign mag_d = i_pass.inv_depth[IN_W-1] ? DENW'(-i_pass.inv_depth)
                                           : DENW'(i_pass.inv_depth);
    assign last_step = (r_cnt == CNTW'(NUMW - 1));

    // One restoring step per lane per cycle.
    always_comb begin
        logic [DENW:0] sh;
        for (int l = 0; l < LANES; l++) begin
            sh = {r_rem[l], r_num[l][NUMW-1]};
            if (sh >= {1'b0, r_den}) begin
                step_rem[l] = DENW'(sh - {1'b0, r_den});
                step_num[l] = {r_num[l][NUMW-2:0], 1'b1};
            end else begin
                step_rem[l] = sh[DENW-1:0];
                step_num[l] = {r_num[l][NUMW-2:0], 1'b0};
            end
        end
    end

    // Saturate the signed quotient to Q16.16.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_neg[l]) begin
                if ((|r_num[l][NUMW-1:COORD_W]) || (r_num[l][COORD_W-1:0] > 32'h8000_0000)) begin
                    sat[l] = 32'h8000_0000;
                end else begin
                    sat[l] = ~r_num[l][COORD_W-1:0] + 32'd1;
                end
            end else begin
                if ((|r_num[l][NUMW-1:COORD_W]) || r_num[l][COORD_W-1]) begin
                    sat[l] = 32'h7FFF_FFFF;
                end else begin
                    sat[l] = r_num[l][COORD_W-1:0];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BACK_IDLE: if (!i_q_empty) n_state = BACK_RUN;
            BACK_RUN:  if (last_step) n_state = BACK_DONE;
            BACK_DONE: if (!r_ovalid || i_pop) n_state = BACK_IDLE;
            default:   n_state = BACK_IDLE;
        endcase
    end

    always_comb begin
        o_q_rd   = (r_state == BACK_IDLE) && !i_q_empty;
        load_out = (r_state == BACK_DONE) && (!r_ovalid || i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_num[0] <= mag_x;
            r_num[1] <= mag_y;
            r_num[2] <= NUMW'(1) << 32;
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= '0;
            end
            r_den  <= mag_d;
            r_neg  <= {i_pass.inv_depth[IN_W-1],
                       i_ray_y[RAY_W-1] ^ i_pass.inv_depth[IN_W-1],
                       i_ray_x[RAY_W-1] ^ i_pass.inv_depth[IN_W-1]};
            r_pass <= i_pass;
            r_cnt  <= '0;
        end else if (r_state == BACK_RUN) begin
            for (int l = 0; l < LANES; l++) begin
                r_num[l] <= step_num[l];
                r_rem[l] <= step_rem[l];
            end
            r_cnt <= r_cnt + CNTW'(1);
        end
        if (load_out) begin
            o_point_x <= sat[0];
            o_point_y <= sat[1];
            o_point_z <= sat[2];
            o_pass    <= r_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BACK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_ovalid;

endmodule

>>> sv/idb_checker.sv
// Port-level checker of the back-projection core and its bind.
module idb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               pready,
    input logic                               empty,
    input logic                               pop,
    input logic signed [idb_pkg::COORD_W-1:0] o_point_x,
    input logic signed [idb_pkg::COORD_W-1:0] o_point_z,
    input logic        [idb_pkg::IDX_W-1:0]   o_point_number
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_point_x) && $stable(o_point_number)))
        else $error("waiting result changed or vanished");

    // Depth magnitude is at least 2^32 / 2^23, never zero.
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_point_z != 0))
        else $error("zero depth on a result");
endmodule

bind inverse_depth_backprojection_core idb_checker u_idb_checker (.*);

>>> sim/tb_inverse_depth_backprojection_core.sv
// Testbench of the inverse depth back-projection core: directed table, then random frames.
module tb_inverse_depth_backprojection_core;
    import idb_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int N_ITEMS    = 900;
    localparam int SETTLE     = 120;      // idle wait after the last expected point
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic signed [IN_W-1:0]   inv_depth;
        logic signed [IN_W-1:0]   variance;
        logic        [INT_W-1:0]  intensity;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
    } t_pixel;

    typedef struct {
        logic signed [COORD_W-1:0] x, y, z;
        logic signed [GRAD_W-1:0]  grad_x, grad_y;
        logic        [INT_W-1:0]   intensity;
        logic signed [IN_W-1:0]    variance;
        logic        [IDX_W-1:0]   index;
        logic        [IDX_W-1:0]   number;
    } t_point;

    // Directed rows: either checked against the predictor or known to be dropped.
    typedef enum logic {ROW_PREDICT, ROW_DROP} t_row_kind;

    typedef struct {
        t_pixel    pix;
        t_row_kind kind;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic push = 1'b0, full;
    logic signed [IN_W-1:0]   i_inv_depth = '0, i_depth_variance = '0;
    logic        [INT_W-1:0]  i_intensity = '0;
    logic signed [GRAD_W-1:0] i_grad_x = '0, i_grad_y = '0;
    logic empty, pop = 1'b0;
    logic signed [COORD_W-1:0] o_point_x, o_point_y, o_point_z;
    logic signed [GRAD_W-1:0]  o_out_grad_x, o_out_grad_y;
    logic        [INT_W-1:0]   o_out_intensity;
    logic signed [IN_W-1:0]    o_out_variance;
    logic        [IDX_W-1:0]   o_pixel_index, o_point_number;

    inverse_depth_backprojection_core dut (.*);

    // Mirror of the block: configuration, scan counters and frame point count.
    t_cfg   cfg_mirror;
    int     scan_col, scan_row;
    int     frame_points;
    t_point point_q[$];
    int     failures = 0;
    int     cycles = 0;
    bit     steady = 1'b0;   // suppress idling on both sides

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic int clamp_dim(int v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the scan for one accepted pixel; return 1 with the point if it is kept.
    function automatic bit project_pixel(t_pixel p, output t_point pt);
        int w, h;
        bit keep;
        longint rx, ry, d;
        w = clamp_dim(int'(cfg_mirror.image_width), MAX_W);
        h = clamp_dim(int'(cfg_mirror.image_height), MAX_H);
        d = p.inv_depth;
        keep = scan_col >= 1 && scan_col + 1 < w && scan_row >= 1 && scan_row + 1 < h
               && p.variance > 0 && d != 0;
        pt = '{default: '0};
        if (keep) begin
            rx = longint'(cfg_mirror.focal_x_inverse) * scan_col + cfg_mirror.center_x_term;
            ry = longint'(cfg_mirror.focal_y_inverse) * scan_row + cfg_mirror.center_y_term;
            pt.x = clip32((rx * 1024) / d);
            pt.y = clip32((ry * 1024) / d);
            pt.z = clip32((64'sd1 <<< 32) / d);
            pt.grad_x = p.grad_x;
            pt.grad_y = p.grad_y;
            pt.intensity = p.intensity;
            pt.variance = p.variance;
            pt.index = IDX_W'(scan_col + scan_row * w);
            pt.number = IDX_W'(frame_points);
            frame_points = (frame_points + 1) & 20'hfffff;
        end
        if (scan_row + 1 >= h) begin
            scan_row = 0;
            if (scan_col + 1 >= w) begin
                scan_col = 0;
                frame_points = 0;
            end else begin
                scan_col = scan_col + 1;
            end
        end else begin
            scan_row = scan_row + 1;
        end
        return keep;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_mirror.image_width = val[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_mirror.image_height = val[DIM_W-1:0];
            REG_FOCAL_X_INV:  cfg_mirror.focal_x_inverse = val[COEF_W-1:0];
            REG_FOCAL_Y_INV:  cfg_mirror.focal_y_inverse = val[COEF_W-1:0];
            REG_CENTER_X:     cfg_mirror.center_x_term = val[COEF_W-1:0];
            REG_CENTER_Y:     cfg_mirror.center_y_term = val[COEF_W-1:0];
            default: ;   // unmapped index: drop the write
        endcase
    endtask

    task automatic reg_check(logic [2:0] idx);
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] mask;
        mask = 32'h00ff_ffff;
        case (idx)
            REG_IMAGE_WIDTH:  begin want = cfg_mirror.image_width;  mask = 32'h7ff; end
            REG_IMAGE_HEIGHT: begin want = cfg_mirror.image_height; mask = 32'h7ff; end
            REG_FOCAL_X_INV:  want = cfg_mirror.focal_x_inverse;
            REG_FOCAL_Y_INV:  want = cfg_mirror.focal_y_inverse;
            REG_CENTER_X:     want = cfg_mirror.center_x_term;
            default:          want = cfg_mirror.center_y_term;
        endcase
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b0; paddr <= ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (want & mask)) begin
            $display("%0t register %0d: expected %h, got %h", $time, idx, want & mask,
                     prdata & mask);
            failures++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // Offer one request, idling at random first; hold push high into the next request.
    task automatic send_pixel(t_pixel p, bit typed_drop);
        t_point pt;
        while (!steady && $urandom_range(0, 99) < 37) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_inv_depth <= p.inv_depth;
        i_depth_variance <= p.variance;
        i_intensity <= p.intensity;
        i_grad_x <= p.grad_x;
        i_grad_y <= p.grad_y;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (project_pixel(p, pt) && !typed_drop) point_q = {point_q, pt};
    endtask

    // Lower push, wait for every expected point, then idle so that any stray point is still caught.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(negedge i_clk) pop <= steady || ($urandom_range(0, 99) >= 37);

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_point pt;
        if (i_rst_n && pop && !empty) begin
            if (point_q.size() == 0) begin
                $display("%0t unexpected point: expected none, got index %0d", $time,
                         o_pixel_index);
                failures++;
            end else begin
                pt = point_q.pop_front();
                check_field("point_x", pt.x, o_point_x);
                check_field("point_y", pt.y, o_point_y);
                check_field("point_z", pt.z, o_point_z);
                check_field("grad_x", pt.grad_x, o_out_grad_x);
                check_field("grad_y", pt.grad_y, o_out_grad_y);
                check_field("intensity", pt.intensity, o_out_intensity);
                check_field("variance", pt.variance, o_out_variance);
                check_field("pixel_index", pt.index, o_pixel_index);
                check_field("point_number", pt.number, o_point_number);
            end
        end
    end

    function automatic t_pixel random_pixel();
        t_pixel p;
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) p.inv_depth = '0;
        else if (pick == 1) p.inv_depth = $urandom();
        else begin
            p.inv_depth = $urandom_range(1, 1 << 18);
            if ($urandom_range(0, 3) == 0) p.inv_depth = -p.inv_depth;
        end
        p.variance = $urandom();
        if ($urandom_range(0, 5) != 0) p.variance[IN_W-1] = 1'b0;
        p.intensity = $urandom();
        p.grad_x = $urandom();
        p.grad_y = $urandom();
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2);    // below range: clamps to three
            1:       return 2047;                   // above range: clamps to the maximum
            2:       return 3;
            default: return $urandom_range(4, 12);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_coef();
        if ($urandom_range(0, 2) == 0) return $urandom();
        return $urandom_range(0, 20000) - 10000;
    endfunction

    initial begin
        t_dir_row dir_tab[20];
        int sent;
        int phase;
        int n;

        cfg_mirror = '{image_width: 640, image_height: 480, focal_x_inverse: 8389,
                       focal_y_inverse: 8389, center_x_term: 0, center_y_term: 0};
        scan_col = 0; scan_row = 0; frame_points = 0;

        // Build a 5x4 frame: interior pixels sit at scan positions 5,6,9,10,13,14.
        foreach (dir_tab[k]) begin
            dir_tab[k].pix = '{inv_depth: 24'sd65536, variance: 24'sd100,
                               intensity: 8'(k * 13), grad_x: 16'(k), grad_y: 16'(-k)};
            dir_tab[k].kind = ROW_DROP;    // border pixel
        end
        dir_tab[5].pix.inv_depth = '0;                       // no depth: dropped
        dir_tab[6].pix.variance = '0;                        // zero variance: dropped
        dir_tab[9].pix.variance = 24'sh800000;               // negative variance: dropped
        dir_tab[10].pix = '{24'sd1, 24'sh7fffff, 8'hff, 16'sh7fff, 16'sh8000};  // saturates
        dir_tab[10].kind = ROW_PREDICT;
        dir_tab[13].pix = '{24'sh800000, 24'sd1, 8'h00, 16'sh8000, 16'sh7fff};
        dir_tab[13].kind = ROW_PREDICT;
        dir_tab[14].pix = '{24'sh7fffff, 24'sd65536, 8'h5a, 16'sd0, 16'sd0};
        dir_tab[14].kind = ROW_PREDICT;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults, then the directed frame at extreme intrinsics.
        for (int r = 0; r < 6; r++) reg_check(3'(r));
        reg_write(REG_IMAGE_WIDTH, 5);
        reg_write(REG_IMAGE_HEIGHT, 4);
        reg_write(REG_FOCAL_X_INV, 32'h007f_ffff);
        reg_write(REG_FOCAL_Y_INV, 32'h0080_0000);
        reg_write(REG_CENTER_X, 32'h0080_0000);
        reg_write(REG_CENTER_Y, 32'h007f_ffff);
        reg_write(3'd6, 32'hffff_ffff);    // unmapped: ignored
        reg_write(3'd7, 32'h0);
        for (int r = 0; r < 6; r++) reg_check(3'(r));
        foreach (dir_tab[k]) send_pixel(dir_tab[k].pix, dir_tab[k].kind == ROW_DROP);
        for (int k = 0; k < 4; k++) send_pixel(random_pixel(), 1'b0);   // next frame starts

        // Random phases; each write lands with the pipe empty, often mid-frame.
        sent = 0;
        phase = 0;
        while (sent < N_ITEMS) begin
            drain();
            steady = (phase == 3);
            reg_write(REG_IMAGE_WIDTH, random_dim());
            reg_write(REG_IMAGE_HEIGHT, random_dim());
            reg_write(REG_FOCAL_X_INV, random_coef());
            reg_write(REG_FOCAL_Y_INV, random_coef());
            reg_write(REG_CENTER_X, random_coef());
            reg_write(REG_CENTER_Y, random_coef());
            if (phase % 4 == 0) reg_check(3'($urandom_range(0, 5)));
            n = $urandom_range(40, 120);
            for (int k = 0; k < n; k++) send_pixel(random_pixel(), 1'b0);
            sent += n;
            phase++;
        end
        steady = 1'b0;

        drain();
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
